// ===== rtl/sdfc_pkg.sv =====
// ----------------------------------------------------------------------------
// sdfc_pkg
// Shared types, constants and CRC step functions for the SD SPI framing engine.
// ----------------------------------------------------------------------------
package sdfc_pkg;

	// Item kinds carried on the input tuser.
	typedef enum logic [1:0] {
		KIND_CMD   = 2'd0,
		KIND_DATA  = 2'd1,
		KIND_SEND  = 2'd2,
		KIND_CHECK = 2'd3
	} kind_t;

	localparam int unsigned IN_DATA_W = 64;
	localparam int unsigned OUT_DATA_W = 8;

	localparam logic [7:0]  CMD_START_BIT   = 8'h40;
	localparam logic [6:0]  CRC7_POLY       = 7'h09;
	localparam logic [15:0] CRC16_POLY      = 16'h1021;
	localparam logic [7:0]  FIXED_CRC_CMD0  = 8'h95;
	localparam logic [7:0]  FIXED_CRC_OTHER = 8'h87;
	localparam logic [15:0] FIXED_CRC16     = 16'hFFFF;

	// Position of the CRC7 byte within a six-word command frame.
	localparam logic [2:0] CMD_LAST_POS = 3'd5;

	// One accepted input item.
	typedef struct packed {
		kind_t       kind;
		logic [5:0]  cmd_index;
		logic [31:0] cmd_arg;
		logic [7:0]  data_byte;
		logic [15:0] received_crc;
	} item_t;

	// One result word.
	typedef struct packed {
		logic [7:0] out_byte;
		logic       crc_ok;
		logic       last;
	} result_t;

	// CRC7 (polynomial 0x09) advanced by one byte, most significant bit first.
	function automatic logic [6:0] crc7_byte(input logic [6:0] crc_in, input logic [7:0] b);
		logic [6:0] crc;
		logic       fb;
		crc = crc_in;
		for (int i = 7; i >= 0; i--) begin
			fb  = crc[6] ^ b[i];
			crc = {crc[5:0], 1'b0};
			if (fb) begin
				crc = crc ^ CRC7_POLY;
			end
		end
		return crc;
	endfunction

	// CRC-16 (polynomial 0x1021) advanced by one byte, most significant bit first.
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC16_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ===== rtl/sdfc_in_reg.sv =====
// ----------------------------------------------------------------------------
// sdfc_in_reg
// Input register: holds one accepted item until the framer has issued its
// final result word.
// ----------------------------------------------------------------------------
module sdfc_in_reg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// [5:0] cmd_index, [37:6] cmd_arg, [45:38] data_byte, [61:46] received_crc
	input  logic [sdfc_pkg::IN_DATA_W-1:0]   s_tdata,
	// [1:0] kind
	input  logic [1:0]                       s_tuser,
	input  logic                             consume,
	output sdfc_pkg::item_t                  item,
	output logic                             item_valid
);
	import sdfc_pkg::*;

	logic  valid_s1;
	item_t item_s1;

	// A new word may enter when the register is empty or its item is leaving.
	assign s_tready = !valid_s1 || consume;

	// Occupancy flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Item payload, unpacked from the stream word.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.kind         <= kind_t'(s_tuser);
			item_s1.cmd_index    <= s_tdata[5:0];
			item_s1.cmd_arg      <= s_tdata[37:6];
			item_s1.data_byte    <= s_tdata[45:38];
			item_s1.received_crc <= s_tdata[61:46];
		end
	end

	assign item       = item_s1;
	assign item_valid = valid_s1;

endmodule

// ===== rtl/sdfc_framer.sv =====
// ----------------------------------------------------------------------------
// sdfc_framer
// Result sequencer: issues the held item's result words one per cycle when
// out_ready allows, advancing the command CRC7 bytewise, keeping data CRC-16.
// ----------------------------------------------------------------------------
module sdfc_framer (
	input  logic                clk,
	input  logic                arst_n,
	input  sdfc_pkg::item_t     item,
	input  logic                item_valid,
	input  logic                out_ready,
	input  logic                crc_enable,
	output sdfc_pkg::result_t   res,
	output logic                res_valid,
	output logic                consume
);
	import sdfc_pkg::*;

	logic [2:0]  pos_q;
	logic [6:0]  crc7_q;
	logic [15:0] crc16_q;

	logic        fire;
	logic [6:0]  crc7_base;
	logic [15:0] crc_send;
	logic [7:0]  cmd_byte;
	logic [7:0]  crc7_out;

	assign fire      = item_valid && out_ready;
	assign res_valid = item_valid;
	assign consume   = fire && res.last;
	assign crc7_base = (pos_q == 3'd0) ? 7'd0 : crc7_q;
	assign crc_send  = crc_enable ? crc16_q : FIXED_CRC16;

	// Closing byte of a command frame.
	always_comb begin
		if (crc_enable) begin
			crc7_out = {crc7_q, 1'b1};
		end else if (item.cmd_index == 6'd0) begin
			crc7_out = FIXED_CRC_CMD0;
		end else begin
			crc7_out = FIXED_CRC_OTHER;
		end
	end

	// Command frame byte at the current position.
	always_comb begin
		unique case (pos_q)
			3'd0:    cmd_byte = CMD_START_BIT | {2'b00, item.cmd_index};
			3'd1:    cmd_byte = item.cmd_arg[31:24];
			3'd2:    cmd_byte = item.cmd_arg[23:16];
			3'd3:    cmd_byte = item.cmd_arg[15:8];
			3'd4:    cmd_byte = item.cmd_arg[7:0];
			default: cmd_byte = crc7_out;
		endcase
	end

	// Result word for the held item and position.
	always_comb begin
		res = '{out_byte: 8'h00, crc_ok: 1'b1, last: 1'b1};
		unique case (item.kind)
			KIND_CMD: begin
				res.out_byte = cmd_byte;
				res.last     = (pos_q == CMD_LAST_POS);
			end
			KIND_DATA: begin
				res.out_byte = item.data_byte;
			end
			KIND_SEND: begin
				res.out_byte = (pos_q == 3'd0) ? crc_send[15:8] : crc_send[7:0];
				res.last     = (pos_q != 3'd0);
			end
			KIND_CHECK: begin
				res.crc_ok = !crc_enable || (item.received_crc == crc16_q);
			end
			default: begin
				res = '{out_byte: 8'h00, crc_ok: 1'b1, last: 1'b1};
			end
		endcase
	end

	// Position counter within the item's results.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 3'd0;
		end else if (fire) begin
			pos_q <= res.last ? 3'd0 : pos_q + 3'd1;
		end
	end

	// Command CRC7, advanced as each of the first five frame bytes goes out.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc7_q <= 7'd0;
		end else if (fire && item.kind == KIND_CMD && pos_q != CMD_LAST_POS) begin
			crc7_q <= crc7_byte(crc7_base, cmd_byte);
		end
	end

	// Running data CRC-16; both end items clear it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc16_q <= 16'd0;
		end else if (fire) begin
			if (item.kind == KIND_DATA) begin
				crc16_q <= crc16_byte(crc16_q, item.data_byte);
			end else if ((item.kind == KIND_SEND || item.kind == KIND_CHECK) && res.last) begin
				crc16_q <= 16'd0;
			end
		end
	end

endmodule

// ===== rtl/sdfc_out_reg.sv =====
// ----------------------------------------------------------------------------
// sdfc_out_reg
// Output register: holds one result word on the master stream until it is
// taken.
// ----------------------------------------------------------------------------
module sdfc_out_reg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  sdfc_pkg::result_t                res,
	input  logic                             res_valid,
	output logic                             out_ready,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [7:0] out_byte
	output logic [sdfc_pkg::OUT_DATA_W-1:0]  m_tdata,
	// [0] crc_ok
	output logic [0:0]                       m_tuser,
	output logic                             m_tlast
);
	import sdfc_pkg::*;

	logic    valid_q;
	result_t res_q;

	// The register can load when it is empty or its word is being taken.
	assign out_ready = !valid_q || m_tready;

	// Valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_ready) begin
			valid_q <= res_valid;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (out_ready && res_valid) begin
			res_q <= res;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = res_q.out_byte;
	assign m_tuser  = res_q.crc_ok;
	assign m_tlast  = res_q.last;

endmodule

// ===== rtl/sd_spi_frame_crc_engine_top.sv =====
// ----------------------------------------------------------------------------
// sd_spi_frame_crc_engine_top
// SD card SPI-mode framing engine with CRC7 command and CRC-16 data checksums.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream takes one item per word: tuser carries the kind (command,
//   data byte, end-send, end-check) and tdata the command index, argument,
//   data byte and received CRC. The master stream returns result words: tdata
//   is the byte to send, tuser the CRC check flag, tlast marks an item's final
//   word. A command gives six words, an end-send two, the others one.
//   The cfg channel writes crc_enable; it is always ready and must be written
//   only while no item is in flight.
// Data path and throughput:
//   An accepted item is held in the input register; the sequencer forms its
//   result words combinationally and each is registered in the output
//   register before it is presented. While the output register can take
//   them, the sequencer issues one result word per cycle, so data bytes
//   stream at one per cycle; the next item loads as the last word goes.
// Reset and stalls:
//   Reset empties both registers, clears the running CRC-16 and sets
//   crc_enable. When the receiver holds tready low, the output word holds,
//   the held item waits in the input register and s_tready falls.
// ----------------------------------------------------------------------------
module sd_spi_frame_crc_engine_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// [5:0] cmd_index, [37:6] cmd_arg, [45:38] data_byte, [61:46] received_crc
	input  logic [sdfc_pkg::IN_DATA_W-1:0]   s_tdata,
	// [1:0] kind
	input  logic [1:0]                       s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [7:0] out_byte
	output logic [sdfc_pkg::OUT_DATA_W-1:0]  m_tdata,
	// [0] crc_ok
	output logic [0:0]                       m_tuser,
	output logic                             m_tlast,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic                             cfg_data
);
	import sdfc_pkg::*;

	item_t   item;
	logic    item_valid;
	logic    consume;
	result_t res;
	logic    res_valid;
	logic    out_ready;
	logic    crc_enable_q;

	// Configuration register.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_enable_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			crc_enable_q <= cfg_data;
		end
	end

	// Input register.
	sdfc_in_reg u_in_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.consume    (consume),
		.item       (item),
		.item_valid (item_valid)
	);

	// Result sequencer and CRC state.
	sdfc_framer u_framer (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.item_valid (item_valid),
		.out_ready  (out_ready),
		.crc_enable (crc_enable_q),
		.res        (res),
		.res_valid  (res_valid),
		.consume    (consume)
	);

	// Output register.
	sdfc_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.res       (res),
		.res_valid (res_valid),
		.out_ready (out_ready),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the SD SPI framing engine with CRC7 and CRC-16.
// ----------------------------------------------------------------------------
// Items are driven on the slave stream and the result words on the master
// stream are checked, in order, against a bit-accurate prediction of the
// command frames, pass-through data bytes, CRC-16 trailers and CRC checks.
// A directed part covers the field extremes and the fixed-CRC behaviour with
// checking disabled. A random part is mostly well-formed data blocks closed
// by an end-send or end-check item, mixed with command frames and noise.
// Both streams idle at random, and the receiver once holds off for a long
// stretch so that the engine fills up and stalls its input.
// ----------------------------------------------------------------------------

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import sdfc_pkg::*;

	// Keeps the expected result words and the engine state they are derived from.
	class frame_scoreboard;
		sdfc_pkg::result_t expected_q[$];
		bit                crc_en;
		logic [15:0]       block_crc;
		int unsigned       n_errors;
		int unsigned       n_words;
		int unsigned       n_items;
		int unsigned       n_kind[4];

		function new();
			crc_en    = 1'b1;
			block_crc = 16'h0000;
			n_errors  = 0;
			n_words   = 0;
			n_items   = 0;
			for (int k = 0; k < 4; k++) begin
				n_kind[k] = 0;
			end
		endfunction

		// The first ten failures are shown in full, later ones only counted.
		function void report(string msg);
			n_errors++;
			if (n_errors <= 10) begin
				$display("[%0t] ERROR: %s", $realtime, msg);
			end
		endfunction

		function void push_word(logic [7:0] b, logic ok, logic lst);
			sdfc_pkg::result_t w;
			w.out_byte = b;
			w.crc_ok   = ok;
			w.last     = lst;
			expected_q.push_back(w);
		endfunction

		// CRC7 over the five header bytes, bit by bit, most significant first.
		function logic [6:0] header_crc7(logic [39:0] hdr);
			logic [6:0] r;
			logic       fb;
			r = 7'h00;
			for (int i = 39; i >= 0; i--) begin
				fb = r[6] ^ hdr[i];
				r  = {r[5:0], 1'b0} ^ (fb ? sdfc_pkg::CRC7_POLY : 7'h00);
			end
			return r;
		endfunction

		// One data byte folded into the block CRC-16, most significant bit first.
		function logic [15:0] fold_crc16(logic [15:0] c, logic [7:0] b);
			logic [15:0] r;
			logic        fb;
			r = c;
			for (int i = 7; i >= 0; i--) begin
				fb = r[15] ^ b[i];
				r  = {r[14:0], 1'b0} ^ (fb ? sdfc_pkg::CRC16_POLY : 16'h0000);
			end
			return r;
		endfunction

		// Works out every result word caused by one accepted item.
		function void note_item(sdfc_pkg::item_t it);
			logic [39:0] hdr;
			logic [15:0] trailer;
			n_items++;
			n_kind[it.kind]++;
			case (it.kind)
				sdfc_pkg::KIND_CMD: begin
					hdr = {sdfc_pkg::CMD_START_BIT | {2'b00, it.cmd_index}, it.cmd_arg};
					for (int k = 4; k >= 1; k--) begin
						push_word(hdr[k*8 +: 8], 1'b1, 1'b0);
					end
					push_word(hdr[7:0], 1'b1, 1'b0);
					if (crc_en) begin
						push_word({header_crc7(hdr), 1'b1}, 1'b1, 1'b1);
					end else if (it.cmd_index == 6'd0) begin
						push_word(sdfc_pkg::FIXED_CRC_CMD0, 1'b1, 1'b1);
					end else begin
						push_word(sdfc_pkg::FIXED_CRC_OTHER, 1'b1, 1'b1);
					end
				end
				sdfc_pkg::KIND_DATA: begin
					// The block CRC runs on even while checking is disabled.
					block_crc = fold_crc16(block_crc, it.data_byte);
					push_word(it.data_byte, 1'b1, 1'b1);
				end
				sdfc_pkg::KIND_SEND: begin
					trailer = crc_en ? block_crc : sdfc_pkg::FIXED_CRC16;
					push_word(trailer[15:8], 1'b1, 1'b0);
					push_word(trailer[7:0], 1'b1, 1'b1);
					block_crc = 16'h0000;
				end
				default: begin
					push_word(8'h00, !crc_en || (it.received_crc == block_crc), 1'b1);
					block_crc = 16'h0000;
				end
			endcase
		endfunction

		// Compares one accepted result word with the oldest expected one.
		function void check_result(sdfc_pkg::result_t got);
			sdfc_pkg::result_t want;
			n_words++;
			if (expected_q.size() == 0) begin
				report($sformatf("unexpected word byte=%02h ok=%0b last=%0b",
					got.out_byte, got.crc_ok, got.last));
				return;
			end
			want = expected_q.pop_front();
			if (got.out_byte !== want.out_byte) begin
				report($sformatf("word %0d: out_byte expected %02h, got %02h",
					n_words, want.out_byte, got.out_byte));
			end
			if (got.crc_ok !== want.crc_ok) begin
				report($sformatf("word %0d: crc_ok expected %0b, got %0b",
					n_words, want.crc_ok, got.crc_ok));
			end
			if (got.last !== want.last) begin
				report($sformatf("word %0d: last expected %0b, got %0b",
					n_words, want.last, got.last));
			end
		endfunction
	endclass

	localparam int unsigned STALL_LIMIT = 2000;
	localparam int unsigned LONG_HOLD   = 80;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;
	logic [0:0]  m_tuser;
	logic        m_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_data;

	frame_scoreboard sb;
	bit              send_idle;
	bit              recv_idle;
	bit              hold_req;
	int unsigned     n_cfg;
	int unsigned     stall_cycles;

	sd_spi_frame_crc_engine_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: ends the run when no word moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= STALL_LIMIT) begin
				$display("FAIL sd_spi_frame_crc_engine_top");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	function automatic item_t make_item(kind_t k, logic [5:0] idx, logic [31:0] arg,
			logic [7:0] b, logic [15:0] rx);
		item_t it;
		it.kind         = k;
		it.cmd_index    = idx;
		it.cmd_arg      = arg;
		it.data_byte    = b;
		it.received_crc = rx;
		return it;
	endfunction

	// Offers one item on the slave stream and waits until it is taken.
	task automatic offer_item(input item_t it);
		int unsigned gap;
		gap = send_idle ? $urandom_range(0, 6) : 0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= it.kind;
		s_tdata  <= {2'b00, it.received_crc, it.data_byte, it.cmd_arg, it.cmd_index};
		do @(posedge clk); while (!s_tready);
		sb.note_item(it);
	endtask

	// Stops offering and waits until every expected word has arrived.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
	endtask

	// Writes crc_enable once the engine has gone quiet.
	task automatic write_crc_enable(input bit value);
		drain_results();
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.crc_en = value;
		n_cfg++;
	endtask

	// A block of data bytes closed by an end-send or an end-check item.
	task automatic send_block(input int unsigned n_bytes);
		logic [15:0] rx;
		for (int i = 0; i < n_bytes; i++) begin
			offer_item(make_item(KIND_DATA, 6'($urandom), $urandom, 8'($urandom), 16'($urandom)));
		end
		if ($urandom_range(0, 1) == 0) begin
			offer_item(make_item(KIND_SEND, 6'($urandom), $urandom, 8'($urandom), 16'($urandom)));
		end else begin
			// Half of the checks carry the right CRC, the others a corrupted one.
			rx = sb.block_crc;
			if ($urandom_range(0, 1) == 0) begin
				rx = rx ^ (16'h0001 << $urandom_range(0, 15));
			end
			offer_item(make_item(KIND_CHECK, 6'($urandom), $urandom, 8'($urandom), rx));
		end
	endtask

	// Random traffic: mostly well-formed blocks, some commands and some noise.
	task automatic run_random(input int unsigned n_items);
		int unsigned start;
		int unsigned pick;
		start = sb.n_items;
		while (sb.n_items - start < n_items) begin
			pick = $urandom_range(0, 9);
			if (pick < 6) begin
				send_block(($urandom_range(0, 7) == 0) ? $urandom_range(9, 24)
					: $urandom_range(1, 8));
			end else if (pick < 8) begin
				offer_item(make_item(KIND_CMD, 6'($urandom), $urandom, 8'($urandom),
					16'($urandom)));
			end else begin
				offer_item(make_item(kind_t'($urandom_range(0, 3)), 6'($urandom), $urandom,
					8'($urandom), 16'($urandom)));
			end
		end
	endtask

	// Receiver: random idling, with one long hold-off when asked for.
	initial begin
		int unsigned gap;
		result_t     got;
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				gap = LONG_HOLD;
				hold_req = 1'b0;
			end else begin
				gap = recv_idle ? $urandom_range(0, 6) : 0;
			end
			if (gap != 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			got.out_byte = m_tdata;
			got.crc_ok   = m_tuser[0];
			got.last     = m_tlast;
			sb.check_result(got);
		end
	end

	// Main stimulus sequence.
	initial begin
		sb           = new();
		send_idle    = 1'b1;
		recv_idle    = 1'b1;
		hold_req     = 1'b0;
		n_cfg        = 0;
		stall_cycles = 0;
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= '0;
		cfg_valid <= 1'b0;
		cfg_data  <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part with CRCs enabled from reset.
		offer_item(make_item(KIND_CMD, 6'd0, 32'h0000_0000, 8'h00, 16'h0000));
		offer_item(make_item(KIND_CMD, 6'd63, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF));
		offer_item(make_item(KIND_CMD, 6'd8, 32'h0000_01AA, 8'h00, 16'h0000));
		offer_item(make_item(KIND_CHECK, 6'd0, 32'h0, 8'h00, 16'h0000));
		offer_item(make_item(KIND_DATA, 6'd0, 32'h0, 8'h00, 16'h0000));
		offer_item(make_item(KIND_DATA, 6'd0, 32'h0, 8'hFF, 16'h0000));
		offer_item(make_item(KIND_DATA, 6'd0, 32'h0, 8'hA5, 16'h0000));
		offer_item(make_item(KIND_SEND, 6'd0, 32'h0, 8'h00, 16'h0000));
		offer_item(make_item(KIND_SEND, 6'd0, 32'h0, 8'h00, 16'h0000));
		offer_item(make_item(KIND_DATA, 6'd0, 32'h0, 8'h5A, 16'h0000));
		offer_item(make_item(KIND_CHECK, 6'd0, 32'h0, 8'h00, sb.block_crc));
		offer_item(make_item(KIND_DATA, 6'd0, 32'h0, 8'h3C, 16'h0000));
		offer_item(make_item(KIND_CHECK, 6'd0, 32'h0, 8'h00, ~sb.block_crc));

		// Directed part with CRCs disabled: fixed trailers, checks always pass.
		write_crc_enable(1'b0);
		offer_item(make_item(KIND_CMD, 6'd0, 32'h0000_0000, 8'h00, 16'h0000));
		offer_item(make_item(KIND_CMD, 6'd17, 32'h1234_5678, 8'h00, 16'h0000));
		offer_item(make_item(KIND_CMD, 6'd63, 32'hFFFF_FFFF, 8'h00, 16'h0000));
		offer_item(make_item(KIND_DATA, 6'd0, 32'h0, 8'hC3, 16'h0000));
		offer_item(make_item(KIND_SEND, 6'd0, 32'h0, 8'h00, 16'h0000));
		offer_item(make_item(KIND_DATA, 6'd0, 32'h0, 8'h81, 16'h0000));
		offer_item(make_item(KIND_CHECK, 6'd0, 32'h0, 8'h00, 16'hFFFF));
		// Bytes fed while disabled still count once checking is back on.
		offer_item(make_item(KIND_DATA, 6'd0, 32'h0, 8'h7E, 16'h0000));
		write_crc_enable(1'b1);
		offer_item(make_item(KIND_SEND, 6'd0, 32'h0, 8'h00, 16'h0000));

		// Random part, first with CRCs enabled.
		run_random(70);

		// Disabled, then a long receiver hold-off against a back-to-back sender.
		write_crc_enable(1'b0);
		run_random(50);
		write_crc_enable(1'b1);
		send_idle = 1'b0;
		recv_idle = 1'b0;
		hold_req  = 1'b1;
		run_random(30);
		send_idle = 1'b1;
		recv_idle = 1'b1;
		run_random(45);

		// Drain and report.
		drain_results();
		repeat (10) @(posedge clk);
		$display("Covered %0d items (cmd %0d, data %0d, send %0d, check %0d), %0d words.",
			sb.n_items, sb.n_kind[KIND_CMD], sb.n_kind[KIND_DATA], sb.n_kind[KIND_SEND],
			sb.n_kind[KIND_CHECK], sb.n_words);
		$display("crc_enable written %0d times; %0d mismatches.", n_cfg, sb.n_errors);
		if (sb.n_errors == 0 && sb.expected_q.size() == 0) begin
			$display("PASS sd_spi_frame_crc_engine_top");
		end else begin
			$display("FAIL sd_spi_frame_crc_engine_top");
		end
		$finish;
	end

endmodule
